// ===== design/krtc_pkg.sv =====
`default_nettype none
package krtc_pkg;

  // Default table size
  localparam int CAPACITY_DEF = 16;

  // Operation codes
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_LIST = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  // Source of the record fields in a result
  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_HIT  = 2'd1;
  localparam logic [1:0] SRC_LIST = 2'd2;

  // Read address select
  localparam logic [1:0] RA_ZERO = 2'd0;
  localparam logic [1:0] RA_IDX  = 2'd1;
  localparam logic [1:0] RA_IDX1 = 2'd2;
  localparam logic [1:0] RA_IDX2 = 2'd3;

  // Scan index update
  localparam logic [1:0] IX_HOLD = 2'd0;
  localparam logic [1:0] IX_ZERO = 2'd1;
  localparam logic [1:0] IX_INC  = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key_id;
    logic [7:0]  year;
    logic [15:0] course1;
    logic [7:0]  grade1;
    logic [15:0] course2;
    logic [7:0]  grade2;
    logic [15:0] course3;
    logic [7:0]  grade3;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic        table_full;
    logic [31:0] rec_id;
    logic [7:0]  rec_year;
    logic [15:0] rec_course1;
    logic [7:0]  rec_grade1;
    logic [15:0] rec_course2;
    logic [7:0]  rec_grade2;
    logic [15:0] rec_course3;
    logic [7:0]  rec_grade3;
    logic        last;
  } rsp_t;

  // One stored record, one RAM word
  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  year;
    logic [15:0] course1;
    logic [7:0]  grade1;
    logic [15:0] course2;
    logic [7:0]  grade2;
    logic [15:0] course3;
    logic [7:0]  grade3;
  } rec_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       wr_add;
    logic       wr_shift;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       hit_load;
    logic [1:0] raddr_sel;
    logic [1:0] idx_op;
    logic       out_load;
    logic [1:0] out_status;
    logic [1:0] out_src;
    logic       out_last;
  } krtc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       cnt_zero;
    logic       full;
    logic       key_hit;
    logic       idx_last;
    logic       shift_last;
    logic       out_free;
  } krtc_stat_t;

endpackage
`default_nettype wire

// ===== design/krtc_ram.sv =====
`default_nettype none
module krtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/krtc_dp.sv =====
`default_nettype none
module krtc_dp import krtc_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire krtc_cmd_t  cmd,
  output krtc_stat_t      st,
  input  wire req_t       req,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  output rsp_t            rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] TWO = CW'(2);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  req_t          item;
  rec_t          hit_rec;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_p1;
  logic [CW-1:0] idx_p2;
  logic          full;

  logic          we;
  logic [AW-1:0] waddr;
  rec_t          wdata;
  logic [AW-1:0] raddr;
  rec_t          rdata;
  logic          out_free;
  rsp_t          rsp_next;

  assign idx_p1   = idx + ONE;
  assign idx_p2   = idx + TWO;
  assign full     = (count == CAP);
  assign out_free = !rsp_valid || rsp_ready;

  // Status back to the controller
  always_comb begin
    st.op         = item.op;
    st.cnt_zero   = (count == '0);
    st.full       = full;
    st.key_hit    = (rdata.key == item.key_id);
    st.idx_last   = (idx_p1 == count);
    st.shift_last = (idx_p2 == count);
    st.out_free   = out_free;
  end

  // Latched request and matched record
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= req;
    end
    if (cmd.hit_load) begin
      hit_rec <= rdata;
    end
  end

  // Record count and scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + ONE;
      end else if (cmd.cnt_dec) begin
        count <= count - ONE;
      end
      case (cmd.idx_op)
        IX_ZERO: idx <= '0;
        IX_INC:  idx <= idx_p1;
        default: idx <= idx;
      endcase
    end
  end

  // Record RAM ports: append at count, compaction writes one slot down
  always_comb begin
    we    = cmd.wr_add || cmd.wr_shift;
    waddr = cmd.wr_add ? count[AW-1:0] : idx[AW-1:0];
    if (cmd.wr_add) begin
      wdata = '{key: item.key_id, year: item.year,
                course1: item.course1, grade1: item.grade1,
                course2: item.course2, grade2: item.grade2,
                course3: item.course3, grade3: item.grade3};
    end else begin
      wdata = rdata;
    end
    case (cmd.raddr_sel)
      RA_ZERO: raddr = '0;
      RA_IDX1: raddr = idx_p1[AW-1:0];
      RA_IDX2: raddr = idx_p2[AW-1:0];
      default: raddr = idx[AW-1:0];
    endcase
  end

  krtc_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Result fields for the next transfer
  always_comb begin
    rsp_next             = '0;
    rsp_next.status      = cmd.out_status;
    rsp_next.entry_count = 5'(count);
    rsp_next.table_full  = full;
    rsp_next.last        = cmd.out_last;
    case (cmd.out_src)
      SRC_HIT: begin
        rsp_next.rec_id      = hit_rec.key;
        rsp_next.rec_year    = hit_rec.year;
        rsp_next.rec_course1 = hit_rec.course1;
        rsp_next.rec_grade1  = hit_rec.grade1;
        rsp_next.rec_course2 = hit_rec.course2;
        rsp_next.rec_grade2  = hit_rec.grade2;
        rsp_next.rec_course3 = hit_rec.course3;
        rsp_next.rec_grade3  = hit_rec.grade3;
      end
      SRC_LIST: begin
        rsp_next.rec_id = rdata.key;
      end
      default: begin
        rsp_next.rec_id = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp <= rsp_next;
    end
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("record count above capacity");
  a_add_room: assert property (@(posedge clk) disable iff (rst) cmd.wr_add |-> !full)
    else $error("append on a full table");
  a_dec_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> count != '0)
    else $error("remove from an empty table");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result overwritten before transfer");

endmodule
`default_nettype wire

// ===== design/krtc_ctrl.sv =====
`default_nettype none
module krtc_ctrl import krtc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire krtc_stat_t st,
  output krtc_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_LIST   = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] emit_status;
  logic [1:0] emit_status_next;
  logic [1:0] emit_src;
  logic [1:0] emit_src_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      emit_status <= ST_OK;
      emit_src    <= SRC_NONE;
    end else begin
      state       <= state_next;
      emit_status <= emit_status_next;
      emit_src    <= emit_src_next;
    end
  end

  // Sequencer
  always_comb begin
    state_next       = state;
    emit_status_next = emit_status;
    emit_src_next    = emit_src;
    req_ready        = 1'b0;
    cmd              = '0;
    cmd.raddr_sel    = RA_IDX;
    cmd.idx_op       = IX_HOLD;
    cmd.out_status   = ST_OK;
    cmd.out_src      = SRC_NONE;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        emit_src_next = SRC_NONE;
        case (st.op)
          OP_ADD: begin
            if (st.full) begin
              emit_status_next = ST_FULL;
            end else begin
              cmd.wr_add       = 1'b1;
              cmd.cnt_inc      = 1'b1;
              emit_status_next = ST_OK;
            end
            state_next = S_EMIT;
          end
          OP_DEL, OP_READ: begin
            if (st.cnt_zero) begin
              emit_status_next = ST_MISS;
              state_next       = S_EMIT;
            end else begin
              cmd.raddr_sel = RA_ZERO;
              cmd.idx_op    = IX_ZERO;
              state_next    = S_SEARCH;
            end
          end
          OP_LIST: begin
            if (st.cnt_zero) begin
              emit_status_next = ST_MISS;
              state_next       = S_EMIT;
            end else begin
              cmd.raddr_sel = RA_ZERO;
              cmd.idx_op    = IX_ZERO;
              state_next    = S_LIST;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      // Linear search; next entry is fetched while this one is compared
      S_SEARCH: begin
        cmd.raddr_sel = RA_IDX1;
        if (st.key_hit) begin
          emit_status_next = ST_OK;
          if (st.op == OP_READ) begin
            cmd.hit_load  = 1'b1;
            emit_src_next = SRC_HIT;
            state_next    = S_EMIT;
          end else if (st.idx_last) begin
            cmd.cnt_dec   = 1'b1;
            emit_src_next = SRC_NONE;
            state_next    = S_EMIT;
          end else begin
            state_next = S_SHIFT;
          end
        end else if (st.idx_last) begin
          emit_status_next = ST_MISS;
          emit_src_next    = SRC_NONE;
          state_next       = S_EMIT;
        end else begin
          cmd.idx_op = IX_INC;
        end
      end
      // Compaction: write entry idx+1 into idx, fetch idx+2
      S_SHIFT: begin
        cmd.wr_shift  = 1'b1;
        cmd.raddr_sel = RA_IDX2;
        cmd.idx_op    = IX_INC;
        if (st.shift_last) begin
          cmd.cnt_dec      = 1'b1;
          emit_status_next = ST_OK;
          emit_src_next    = SRC_NONE;
          state_next       = S_EMIT;
        end
      end
      // One result per key; refetch the same entry while the output stalls
      S_LIST: begin
        if (st.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_src   = SRC_LIST;
          cmd.out_last  = st.idx_last;
          cmd.raddr_sel = RA_IDX1;
          cmd.idx_op    = IX_INC;
          if (st.idx_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = emit_status;
          cmd.out_src    = emit_src;
          cmd.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> state == S_DECODE)
    else $error("accepted request not decoded");
  a_single_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_add && cmd.wr_shift))
    else $error("two RAM writes in one cycle");
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && st.out_free) |=> state == S_IDLE)
    else $error("single result did not end the operation");

endmodule
`default_nettype wire

// ===== design/keyed_record_table_compacting_top.sv =====
// Channel  Signals                      Payload  Transfer when
// request  req_valid, req_ready, req    req_t    req_valid && req_ready
// result   rsp_valid, rsp_ready, rsp    rsp_t    rsp_valid && rsp_ready
//
// One operation at a time. Add: appends at the end unless the table is full.
// Read/delete: linear search over the record RAM, one entry per cycle; for a
// delete the compaction then moves each later record one slot down. List: one
// key per cycle unless the output stalls. The RAM's single read port sets these rates.
// Synchronous reset empties the table; stored records need no clearing.
// A stalled result holds in the output register; a list pauses until it drains.
`default_nettype none
module keyed_record_table_compacting_top import krtc_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  krtc_cmd_t  cmd;
  krtc_stat_t st;

  krtc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  krtc_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire
